/* rtl/segment_pair_intersection_test_core_assert.svh */
// Assertion macros for the segment pair intersection test core.
// Used by the port-level checker; needs nothing else.
`ifndef SEGMENT_PAIR_INTERSECTION_TEST_CORE_ASSERT_SVH
`define SEGMENT_PAIR_INTERSECTION_TEST_CORE_ASSERT_SVH

// Implication checked while out of reset.
`define SPIT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define SPIT_ASSERT_NXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spit_pkg.sv */
// Shared types, widths and helper functions for the segment pair
// intersection test pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int NUM_ORIENT = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  // Three-valued sign: positive is neither flag, collinear is zero.
  typedef struct packed {
    logic neg;
    logic zero;
  } orient_t;

  // Stage 1: edge vectors, vectors to the test points, box hits.
  typedef struct packed {
    diff_t                  dx_a;
    diff_t                  dy_a;
    diff_t                  dx_b;
    diff_t                  dy_b;
    diff_t [NUM_ORIENT-1:0] rx;
    diff_t [NUM_ORIENT-1:0] ry;
    logic  [NUM_ORIENT-1:0] in_box;
  } s1_t;

  // Stage 2: the two products of each cross product.
  typedef struct packed {
    prod_t [NUM_ORIENT-1:0] lhs;
    prod_t [NUM_ORIENT-1:0] rhs;
    logic  [NUM_ORIENT-1:0] in_box;
  } s2_t;

  // Stage 3: orientation signs.
  typedef struct packed {
    orient_t [NUM_ORIENT-1:0] ori;
    logic    [NUM_ORIENT-1:0] in_box;
  } s3_t;

  function automatic diff_t coord_sub(input coord_t a, input coord_t b);
    coord_sub = diff_t'(a) - diff_t'(b);
  endfunction

  // x in [min(ax,bx), max(ax,bx)] without forming min and max.
  function automatic logic in_range(input coord_t x, input coord_t a, input coord_t b);
    in_range = ((x >= a) || (x >= b)) && ((x <= a) || (x <= b));
  endfunction

  function automatic logic in_box(input coord_t x, input coord_t y,
                                 input coord_t ax, input coord_t ay,
                                 input coord_t bx, input coord_t by);
    in_box = in_range(x, ax, bx) && in_range(y, ay, by);
  endfunction

endpackage

`default_nettype wire

/* rtl/spit_diff.sv */
// Stage 1: coordinate differences and closed bounding box tests.
// Depends on spit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spit_diff import spit_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire coord_t asx,
  input  wire coord_t asy,
  input  wire coord_t aex,
  input  wire coord_t aey,
  input  wire coord_t bsx,
  input  wire coord_t bsy,
  input  wire coord_t bex,
  input  wire coord_t bey,
  output logic        s1_valid,
  input  wire logic   s1_ready,
  output s1_t         s1
);

  logic valid_r;
  s1_t  data_r;
  s1_t  data_nxt;

  always_comb begin
    data_nxt.dx_a = coord_sub(aex, asx);
    data_nxt.dy_a = coord_sub(aey, asy);
    data_nxt.dx_b = coord_sub(bex, bsx);
    data_nxt.dy_b = coord_sub(bey, bsy);
    // Test points against segment A (pivot Ae) and segment B (pivot Be).
    data_nxt.rx[0] = coord_sub(bsx, aex);
    data_nxt.ry[0] = coord_sub(bsy, aey);
    data_nxt.rx[1] = coord_sub(bex, aex);
    data_nxt.ry[1] = coord_sub(bey, aey);
    data_nxt.rx[2] = coord_sub(asx, bex);
    data_nxt.ry[2] = coord_sub(asy, bey);
    data_nxt.rx[3] = coord_sub(aex, bex);
    data_nxt.ry[3] = coord_sub(aey, bey);
    data_nxt.in_box[0] = in_box(bsx, bsy, asx, asy, aex, aey);
    data_nxt.in_box[1] = in_box(bex, bey, asx, asy, aex, aey);
    data_nxt.in_box[2] = in_box(asx, asy, bsx, bsy, bex, bey);
    data_nxt.in_box[3] = in_box(aex, aey, bsx, bsy, bex, bey);
  end

  assign in_ready = !valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1       = data_r;

endmodule

`default_nettype wire

/* rtl/spit_mul.sv */
// Stage 2: the eight 17x17 signed products of the four cross products.
// Depends on spit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spit_mul import spit_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic s1_valid,
  output logic      s1_ready,
  input  wire s1_t  s1,
  output logic      s2_valid,
  input  wire logic s2_ready,
  output s2_t       s2
);

  logic valid_r;
  s2_t  data_r;
  s2_t  data_nxt;

  always_comb begin
    for (int k = 0; k < NUM_ORIENT; k++) begin
      if (k < NUM_ORIENT / 2) begin
        data_nxt.lhs[k] = prod_t'(s1.dy_a) * prod_t'($signed(s1.rx[k]));
        data_nxt.rhs[k] = prod_t'(s1.dx_a) * prod_t'($signed(s1.ry[k]));
      end else begin
        data_nxt.lhs[k] = prod_t'(s1.dy_b) * prod_t'($signed(s1.rx[k]));
        data_nxt.rhs[k] = prod_t'(s1.dx_b) * prod_t'($signed(s1.ry[k]));
      end
    end
    data_nxt.in_box = s1.in_box;
  end

  assign s1_ready = !valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_ready) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      data_r <= data_nxt;
    end
  end

  assign s2_valid = valid_r;
  assign s2       = data_r;

endmodule

`default_nettype wire

/* rtl/spit_orient.sv */
// Stage 3: subtract the product pairs and reduce each to a sign.
// Depends on spit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spit_orient import spit_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic s2_valid,
  output logic      s2_ready,
  input  wire s2_t  s2,
  output logic      s3_valid,
  input  wire logic s3_ready,
  output s3_t       s3
);

  logic   valid_r;
  s3_t    data_r;
  s3_t    data_nxt;
  cross_t cross_val [NUM_ORIENT];

  always_comb begin
    for (int k = 0; k < NUM_ORIENT; k++) begin
      cross_val[k] = cross_t'($signed(s2.lhs[k])) - cross_t'($signed(s2.rhs[k]));
      data_nxt.ori[k].neg  = cross_val[k][CROSS_BITS-1];
      data_nxt.ori[k].zero = (cross_val[k] == '0);
    end
    data_nxt.in_box = s2.in_box;
  end

  assign s2_ready = !valid_r || s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s2_ready) begin
      valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      data_r <= data_nxt;
    end
  end

  assign s3_valid = valid_r;
  assign s3       = data_r;

endmodule

`default_nettype wire

/* rtl/segment_pair_intersection_test_core.sv */
// Segment pair intersection test, four-stage pipeline.
// Pipeline: four register stages (differences, products, signs, result register).
// Throughput: one segment pair per cycle; each stage
// holds its word only while the stage after it is full and stalled.
// Reset: synchronous, active low; clears every stage valid, drops words in flight.
`timescale 1ns / 1ps
`default_nettype none

module segment_pair_intersection_test_core import spit_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire coord_t in_seg_a_start_x,
  input  wire coord_t in_seg_a_start_y,
  input  wire coord_t in_seg_a_end_x,
  input  wire coord_t in_seg_a_end_y,
  input  wire coord_t in_seg_b_start_x,
  input  wire coord_t in_seg_b_start_y,
  input  wire coord_t in_seg_b_end_x,
  input  wire coord_t in_seg_b_end_y,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic        out_intersects,
  output logic        out_general_cross
);

  logic in_ready;
  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_valid, s3_ready;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;

  logic out_valid_r;
  logic intersects_r, intersects_nxt;
  logic general_r, general_nxt;

  spit_diff u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .asx      (in_seg_a_start_x),
    .asy      (in_seg_a_start_y),
    .aex      (in_seg_a_end_x),
    .aey      (in_seg_a_end_y),
    .bsx      (in_seg_b_start_x),
    .bsy      (in_seg_b_start_y),
    .bex      (in_seg_b_end_x),
    .bey      (in_seg_b_end_y),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  spit_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  spit_orient u_orient (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3       (s3)
  );

  // Signs differ when either flag differs.
  always_comb begin
    general_nxt    = (s3.ori[0] != s3.ori[1]) && (s3.ori[2] != s3.ori[3]);
    intersects_nxt = general_nxt;
    for (int k = 0; k < NUM_ORIENT; k++) begin
      intersects_nxt = intersects_nxt || (s3.ori[k].zero && s3.in_box[k]);
    end
  end

  assign s3_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_ready) begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      intersects_r <= intersects_nxt;
      general_r    <= general_nxt;
    end
  end

  assign in_stall          = !in_ready;
  assign out_valid         = out_valid_r;
  assign out_intersects    = intersects_r;
  assign out_general_cross = general_r;

endmodule

`default_nettype wire

/* rtl/spit_checker.sv */
// Port-level checker for the segment pair intersection test core, bound to it.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_pair_intersection_test_core_assert.svh"

module spit_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_intersects,
  input wire logic out_general_cross
);

  // Reset empties the pipeline.
  `SPIT_ASSERT_NXT(a_reset_empty, clk, !rst_n, !out_valid, "out_valid after reset")

  // A stalled word holds.
  `SPIT_ASSERT_IMP(a_hold, clk, rst_n, out_valid && out_stall, ##1 (out_valid && $stable(out_intersects) && $stable(out_general_cross)), "stalled word changed")

  // The general rule is a subset of the full test.
  `SPIT_ASSERT_IMP(a_gen_subset, clk, rst_n, out_valid && out_general_cross, out_intersects, "general_cross without intersects")

  // Only a stalled full output register can back up to the input.
  `SPIT_ASSERT_IMP(a_no_false_stall, clk, rst_n, !out_valid || !out_stall, !in_stall, "input stalled with room")

endmodule

bind segment_pair_intersection_test_core spit_checker u_spit_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_intersects    (out_intersects),
  .out_general_cross (out_general_cross)
);

`default_nettype wire

/* test/segment_pair_intersection_test_core_tb.sv */
// Self-checking bench for segment_pair_intersection_test_core: drives segment
// pairs, predicts both crossing flags, checks every result word in order.
// Depends on spit_pkg and the core RTL only.
`timescale 1ns / 1ps

module segment_pair_intersection_test_core_tb;
  import spit_pkg::*;

  typedef enum {TURN_CW, TURN_CCW, TURN_COLLINEAR} turn_t;

  typedef struct {
    coord_t a_sx;
    coord_t a_sy;
    coord_t a_ex;
    coord_t a_ey;
    coord_t b_sx;
    coord_t b_sy;
    coord_t b_ex;
    coord_t b_ey;
  } seg_pair_t;

  typedef struct {
    bit meets;
    bit general;
  } crossing_flags_t;

  class crossing_scoreboard;
    crossing_flags_t pending_flags[$];
    int errors;
    int checked;
    int meets_seen;
    int general_seen;

    function turn_t turn_of(longint px, longint py, longint qx, longint qy,
                            longint rx, longint ry);
      longint cross_val;
      cross_val = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
      if (cross_val > 0) return TURN_CW;
      if (cross_val < 0) return TURN_CCW;
      return TURN_COLLINEAR;
    endfunction

    function bit within_box(longint x, longint y, longint ax, longint ay,
                            longint bx, longint by);
      longint lox, hix, loy, hiy;
      lox = (ax < bx) ? ax : bx;
      hix = (ax > bx) ? ax : bx;
      loy = (ay < by) ? ay : by;
      hiy = (ay > by) ? ay : by;
      return x >= lox && x <= hix && y >= loy && y <= hiy;
    endfunction

    function crossing_flags_t predict_crossing(seg_pair_t p);
      longint asx, asy, aex, aey, bsx, bsy, bex, bey;
      turn_t t1, t2, t3, t4;
      crossing_flags_t f;
      asx = p.a_sx; asy = p.a_sy; aex = p.a_ex; aey = p.a_ey;
      bsx = p.b_sx; bsy = p.b_sy; bex = p.b_ex; bey = p.b_ey;
      t1 = turn_of(asx, asy, aex, aey, bsx, bsy);
      t2 = turn_of(asx, asy, aex, aey, bex, bey);
      t3 = turn_of(bsx, bsy, bex, bey, asx, asy);
      t4 = turn_of(bsx, bsy, bex, bey, aex, aey);
      f.general = (t1 != t2) && (t3 != t4);
      f.meets = f.general
        || (t1 == TURN_COLLINEAR && within_box(bsx, bsy, asx, asy, aex, aey))
        || (t2 == TURN_COLLINEAR && within_box(bex, bey, asx, asy, aex, aey))
        || (t3 == TURN_COLLINEAR && within_box(asx, asy, bsx, bsy, bex, bey))
        || (t4 == TURN_COLLINEAR && within_box(aex, aey, bsx, bsy, bex, bey));
      return f;
    endfunction

    function void note_pair(seg_pair_t p);
      pending_flags.push_back(predict_crossing(p));
    endfunction

    function void check_flags(bit meets, bit general);
      crossing_flags_t want;
      if (pending_flags.size() == 0) begin
        $display("%0t: result word with nothing pending (intersects=%0b general_cross=%0b)",
                 $time, meets, general);
        errors++;
        return;
      end
      want = pending_flags.pop_front();
      checked++;
      if (meets) meets_seen++;
      if (general) general_seen++;
      if (meets !== want.meets) begin
        $display("%0t: intersects mismatch, expected %0b actual %0b",
                 $time, want.meets, meets);
        errors++;
      end
      if (general !== want.general) begin
        $display("%0t: general_cross mismatch, expected %0b actual %0b",
                 $time, want.general, general);
        errors++;
      end
    endfunction
  endclass

  localparam int RANDOM_PER_PHASE = 477;

  logic   clk;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_seg_a_start_x = '0;
  coord_t in_seg_a_start_y = '0;
  coord_t in_seg_a_end_x = '0;
  coord_t in_seg_a_end_y = '0;
  coord_t in_seg_b_start_x = '0;
  coord_t in_seg_b_start_y = '0;
  coord_t in_seg_b_end_x = '0;
  coord_t in_seg_b_end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   out_intersects;
  logic   out_general_cross;

  int idle_pct = 0;
  int stall_pct = 0;
  int pairs_sent = 0;

  crossing_scoreboard sb = new();

  segment_pair_intersection_test_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_seg_a_start_x  (in_seg_a_start_x),
    .in_seg_a_start_y  (in_seg_a_start_y),
    .in_seg_a_end_x    (in_seg_a_end_x),
    .in_seg_a_end_y    (in_seg_a_end_y),
    .in_seg_b_start_x  (in_seg_b_start_x),
    .in_seg_b_start_y  (in_seg_b_start_y),
    .in_seg_b_end_x    (in_seg_b_end_x),
    .in_seg_b_end_y    (in_seg_b_end_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_intersects    (out_intersects),
    .out_general_cross (out_general_cross)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: pick stall at the falling edge, take words at the rising edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_flags(out_intersects, out_general_cross);
  end

  function automatic seg_pair_t make_pair(int asx, int asy, int aex, int aey,
                                          int bsx, int bsy, int bex, int bey);
    seg_pair_t p;
    p.a_sx = coord_t'(asx); p.a_sy = coord_t'(asy);
    p.a_ex = coord_t'(aex); p.a_ey = coord_t'(aey);
    p.b_sx = coord_t'(bsx); p.b_sy = coord_t'(bsy);
    p.b_ex = coord_t'(bex); p.b_ey = coord_t'(bey);
    return p;
  endfunction

  function automatic int any_coord();
    return int'(coord_t'($urandom));
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic int grid_coord();
    return $urandom_range(8) - 4;
  endfunction

  // Mix of shapes: most random pairs are built to land near the decision
  // boundary, the rest are arbitrary.
  function automatic seg_pair_t random_pair();
    int kind, px, py, dx, dy, c;
    kind = $urandom_range(99);
    if (kind < 25) begin
      return make_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                       any_coord(), any_coord(), any_coord(), any_coord());
    end else if (kind < 45) begin
      return make_pair(grid_coord(), grid_coord(), grid_coord(), grid_coord(),
                       grid_coord(), grid_coord(), grid_coord(), grid_coord());
    end else if (kind < 65) begin
      // all four points on one line
      px = $urandom_range(2000) - 1000;
      py = $urandom_range(2000) - 1000;
      dx = $urandom_range(100) - 50;
      dy = $urandom_range(100) - 50;
      return make_pair(px + dx * ($urandom_range(40) - 20), py + dy * 0,
                       px + dx * ($urandom_range(40) - 20), py,
                       px, py, px, py);
    end else if (kind < 75) begin
      c = any_coord();
      if ($urandom_range(1))
        return make_pair(any_coord(), c, any_coord(), c, any_coord(), c, any_coord(), c);
      return make_pair(any_coord(), c, any_coord(), c, c, any_coord(), c, any_coord());
    end else if (kind < 88) begin
      // shared or touching end point
      px = any_coord();
      py = any_coord();
      return make_pair(any_coord(), any_coord(), px, py, px, py, any_coord(), any_coord());
    end
    return make_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                     edge_coord(), edge_coord(), edge_coord(), edge_coord());
  endfunction

  // Points p + t*d with independent t for every end point.
  function automatic seg_pair_t collinear_pair();
    int px, py, dx, dy, t0, t1, t2, t3;
    px = $urandom_range(2000) - 1000;
    py = $urandom_range(2000) - 1000;
    dx = $urandom_range(100) - 50;
    dy = $urandom_range(100) - 50;
    t0 = $urandom_range(40) - 20;
    t1 = $urandom_range(40) - 20;
    t2 = $urandom_range(40) - 20;
    t3 = $urandom_range(40) - 20;
    return make_pair(px + dx * t0, py + dy * t0, px + dx * t1, py + dy * t1,
                     px + dx * t2, py + dy * t2, px + dx * t3, py + dy * t3);
  endfunction

  // Enter at a falling edge, leave at the falling edge after the accept.
  task automatic send_pair(seg_pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_seg_a_start_x <= p.a_sx;
    in_seg_a_start_y <= p.a_sy;
    in_seg_a_end_x   <= p.a_ex;
    in_seg_a_end_y   <= p.a_ey;
    in_seg_b_start_x <= p.b_sx;
    in_seg_b_start_y <= p.b_sy;
    in_seg_b_end_x   <= p.b_ex;
    in_seg_b_end_y   <= p.b_ey;
    do @(posedge clk); while (in_stall);
    sb.note_pair(p);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_flags.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int sender_idle, int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if ($urandom_range(99) < 15) send_pair(collinear_pair());
      else send_pair(random_pair());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));          // parallel
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));          // collinear overlap
    send_pair(make_pair(0, 0, 10, 0, 11, 0, 20, 0));         // collinear apart
    send_pair(make_pair(0, 0, 10, 0, 10, 0, 20, 0));         // collinear touch
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 10));          // T junction
    send_pair(make_pair(0, 0, 10, 10, 10, 10, 20, 0));       // shared end point
    send_pair(make_pair(3, 3, 3, 3, 0, 0, 10, 10));          // point on segment
    send_pair(make_pair(3, 4, 3, 4, 0, 0, 10, 10));          // point off segment
    send_pair(make_pair(20, 20, 20, 20, 0, 0, 10, 10));      // point on line, past end
    send_pair(make_pair(1, 1, 1, 1, 2, 2, 2, 2));            // two distinct points
    send_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 10));          // near miss
    send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_pair(make_pair(0, -32768, 0, 32767, 0, 32767, 0, -32768));
    send_pair(make_pair(0, 0, 10, 0, 20, 0, 25, 5));
    send_pair(make_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    send_pair(make_pair(10, 0, 0, 0, 5, -5, 5, 5));
    send_pair(make_pair(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768));

    run_phase(31, 79);
    // hold the sender until the pipe is empty
    drain_results();
    run_phase(79, 31);
    drain_results();
    run_phase(0, 0);

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d segment pairs under three idle/stall mixes; checked %0d results.",
             pairs_sent, sb.checked);
    $display("Results: %0d meeting, %0d crossing in general position, %0d mismatches.",
             sb.meets_seen, sb.general_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results pending.", sb.pending_flags.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
